### rtl/sigma_from_innovation_interp_macros.svh
// ----------------------------------------------------------------------------
// sigma_from_innovation_interp_macros
// Assertion macros shared by the sigma lookup RTL.
// ----------------------------------------------------------------------------
`ifndef SIGMA_FROM_INNOVATION_INTERP_MACROS_SVH
`define SIGMA_FROM_INNOVATION_INTERP_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define SFI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// condition must never be seen out of reset
`define SFI_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define SFI_ASSERT(label, clk, rst, prop)
`define SFI_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### rtl/sfi_pkg.sv
// ----------------------------------------------------------------------------
// sfi_pkg
// Types and constants for the sigma-from-innovation lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sfi_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  // configuration register indexes
  localparam logic [7:0] CFG_INNOV_MODE = 8'd0;
  localparam logic [7:0] CFG_POINTS     = 8'd1;

  // what the back end must do with an item
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_MISS,
    KIND_CALC
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [33:0] resid;
    logic [3:0]         idx;
    logic [31:0]        grid;
    logic [31:0]        variance;
  } item_t;

endpackage
`default_nettype wire

### rtl/sfi_front.sv
// ----------------------------------------------------------------------------
// sfi_front
// Classifies incoming beats and forms the centered innovation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sfi_front (
  input  wire logic [135:0]       tdata,
  input  wire logic [2:0]         tuser,
  input  wire logic signed [31:0] innovation_mode,
  output sfi_pkg::item_t          item
);

  logic signed [33:0] obs_x;
  logic signed [33:0] mod_x;
  logic signed [33:0] mode_x;

  // sign-extend so the double subtraction is exact
  assign obs_x  = {{2{tdata[31]}}, tdata[31:0]};
  assign mod_x  = {{2{tdata[63]}}, tdata[63:32]};
  assign mode_x = {{2{innovation_mode[31]}}, innovation_mode};

  always_comb begin
    item.resid    = obs_x - mod_x - mode_x;
    item.idx      = tdata[67:64];
    item.grid     = tdata[99:68];
    item.variance = tdata[131:100];
    if (tuser[0]) begin
      item.kind = sfi_pkg::KIND_LOAD;
    end else if (tuser[1] || tuser[2]) begin
      item.kind = sfi_pkg::KIND_MISS;
    end else begin
      item.kind = sfi_pkg::KIND_CALC;
    end
  end

endmodule
`default_nettype wire

### rtl/sfi_queue.sv
// ----------------------------------------------------------------------------
// sfi_queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sigma_from_innovation_interp_macros.svh"
module sfi_queue #(
  parameter int DEPTH = sfi_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire sfi_pkg::item_t wr_item,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output sfi_pkg::item_t      rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfi_pkg::item_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SFI_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `SFI_ASSERT(a_push_grows, clk, rst, push && !pop |=> count == $past(count) + 1'b1)
  `SFI_ASSERT(a_pop_shrinks, clk, rst, pop && !push |=> count == $past(count) - 1'b1)

endmodule
`default_nettype wire

### rtl/sfi_back.sv
// ----------------------------------------------------------------------------
// sfi_back
// Table store, segment search, interpolation, square root and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sigma_from_innovation_interp_macros.svh"
module sfi_back #(
  parameter int MAX_POINTS = sfi_pkg::MAX_POINTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [4:0]     points_in_use,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire sfi_pkg::item_t item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [23:0]         sigma,
  output logic                out_miss
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST_RD,
    ST_LAST_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t             state;
  logic [63:0]        mem [MAX_POINTS];
  logic [AW-1:0]      addr;
  logic [63:0]        rd_q;
  logic [NW-1:0]      npts;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      scan_i;
  logic signed [33:0] resid;
  logic signed [33:0] rd_grid;
  logic [31:0]        rd_var;
  logic [31:0]        x0;
  logic [31:0]        y0;
  logic [31:0]        dr;
  logic [31:0]        dx;
  logic [31:0]        dy;
  logic               neg;
  logic [63:0]        dv_sh;
  logic [31:0]        dv_rem;
  logic [32:0]        dv_try;
  logic [5:0]         cnt;
  logic [47:0]        sq_op;
  logic [25:0]        sq_rem;
  logic [23:0]        sq_root;
  logic [26:0]        sq_try;
  logic [26:0]        sq_sub;
  logic [31:0]        q_fix;
  logic [23:0]        res_sigma;
  logic               res_miss;
  logic               load_ok;

  assign item_ready = (state == ST_IDLE);
  assign rd_grid    = {{2{rd_q[63]}}, rd_q[63:32]};
  assign rd_var     = rd_q[31:0];
  assign load_ok    = int'(item.idx) < MAX_POINTS;

  // saturated count of points in use
  always_comb begin
    if (points_in_use == '0) begin
      npts = NW'(1);
    end else if (int'(points_in_use) > MAX_POINTS) begin
      npts = NW'(MAX_POINTS);
    end else begin
      npts = NW'(points_in_use);
    end
    last_idx = AW'(npts - 1'b1);
  end

  // one division and one root step per cycle
  assign dv_try = {dv_rem, dv_sh[63]};
  assign sq_try = {sq_rem[24:0], sq_op[47:46]};
  assign sq_sub = {1'b0, sq_root, 2'b01};
  assign q_fix  = dv_sh[31:0] + {31'b0, (neg && (dv_rem != '0))};

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid && item.kind == sfi_pkg::KIND_LOAD && load_ok) begin
      mem[AW'(item.idx)] <= {item.grid, item.variance};
    end
    rd_q <= mem[addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            resid <= item.resid;
            addr  <= last_idx;
            case (item.kind)
              sfi_pkg::KIND_MISS: begin
                res_sigma <= '0;
                res_miss  <= 1'b1;
                state     <= ST_DONE;
              end
              sfi_pkg::KIND_CALC: begin
                state <= ST_LAST_RD;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_LAST_RD: begin
          state <= ST_LAST_CHK;
        end
        // clamp above the last point first
        ST_LAST_CHK: begin
          if (npts == NW'(1) || resid >= rd_grid) begin
            sq_op   <= {rd_var, 16'b0};
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
            state   <= ST_SQRT;
          end else begin
            addr   <= '0;
            scan_i <= '0;
            state  <= ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        // walk the grid for the enclosing segment
        ST_SCAN_CHK: begin
          if (scan_i == '0 && resid <= rd_grid) begin
            sq_op   <= {rd_var, 16'b0};
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
            state   <= ST_SQRT;
          end else if (scan_i != '0 && (scan_i == last_idx || rd_grid > resid)) begin
            dr    <= resid[31:0] - x0;
            dx    <= rd_q[63:32] - x0;
            dy    <= (rd_var >= y0) ? rd_var - y0 : y0 - rd_var;
            neg   <= (rd_var < y0);
            state <= ST_MUL;
          end else begin
            x0     <= rd_q[63:32];
            y0     <= rd_var;
            scan_i <= scan_i + 1'b1;
            addr   <= scan_i + 1'b1;
            state  <= ST_SCAN_RD;
          end
        end
        ST_MUL: begin
          dv_sh  <= dr * dy;
          dv_rem <= '0;
          cnt    <= '0;
          state  <= ST_DIV;
        end
        // restoring divide, one quotient bit per cycle
        ST_DIV: begin
          if (dv_try >= {1'b0, dx}) begin
            dv_rem <= 32'(dv_try - {1'b0, dx});
            dv_sh  <= {dv_sh[62:0], 1'b1};
          end else begin
            dv_rem <= dv_try[31:0];
            dv_sh  <= {dv_sh[62:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) begin
            state <= ST_FIX;
          end
        end
        // round toward minus infinity on a falling segment
        ST_FIX: begin
          sq_op   <= {(neg ? y0 - q_fix : y0 + q_fix), 16'b0};
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= '0;
          state   <= ST_SQRT;
        end
        // digit-by-digit square root, one result bit per cycle
        ST_SQRT: begin
          sq_op <= {sq_op[45:0], 2'b00};
          if (sq_try >= sq_sub) begin
            sq_rem  <= 26'(sq_try - sq_sub);
            sq_root <= {sq_root[22:0], 1'b1};
          end else begin
            sq_rem  <= sq_try[25:0];
            sq_root <= {sq_root[22:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd23) begin
            res_sigma <= (sq_try >= sq_sub) ? {sq_root[22:0], 1'b1} : {sq_root[22:0], 1'b0};
            res_miss  <= 1'b0;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            sigma     <= res_sigma;
            out_miss  <= res_miss;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SFI_ASSERT(a_miss_zero, clk, rst, out_valid && out_miss |-> sigma == '0)
  `SFI_ASSERT(a_dx_nonzero, clk, rst, state == ST_DIV |-> dx != '0)
  `SFI_ASSERT(a_scan_bound, clk, rst, state == ST_SCAN_CHK |-> scan_i <= last_idx)

endmodule
`default_nettype wire

### rtl/sigma_from_innovation_interp.sv
// Sigma lookup from a piecewise-linear variance table.
// Input stream s_*: one beat per item. s_tuser[0] = op (1 loads table entry
// entry_index, 0 computes sigma), s_tuser[1]/[2] = obs/model missing flags.
// Output stream m_*: one beat per compute item, in order; loads give none.
// m_tdata = sigma (unsigned Q8.16), m_tuser = missing flag.
// Config port cfg_*: index 0 innovation mode, 1 points in use; write only
// while the block is idle. cfg_ready is always high.
// In the back end a load is written to the table as it is accepted and a
// missing item goes straight to the output stage. A computed item walks the
// grid for its segment, one table point at a time, then passes the multiply,
// the restoring divider (one bit per cycle) and the square root unit (one
// bit per cycle). An item clamped above or below the grid skips the divider.
// The back end holds one item at a time and takes the next only once the
// result of the last has moved to the output register.
// A two-entry queue lets the input side keep taking beats while the back
// end works, and an output register holds a result while m_tready is low,
// the back end then waiting with its next result.
// Reset (rst, synchronous) clears control state and the registers to
// mode 0 and one point; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// sigma_from_innovation_interp
// Top level: config registers, front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sigma_from_innovation_interp #(
  parameter int MAX_POINTS = sfi_pkg::MAX_POINTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // obs_value, model_value, entry_index, grid_point, variance_value, pad
  input  wire logic [135:0] s_tdata,
  // op, obs_missing, model_missing
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // sigma
  output logic [23:0]       m_tdata,
  // sigma_missing
  output logic              m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic signed [31:0] innovation_mode;
  logic [4:0]         points_in_use;
  sfi_pkg::item_t     front_item;
  sfi_pkg::item_t     q_item;
  logic               q_valid;
  logic               q_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      innovation_mode <= '0;
      points_in_use   <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == sfi_pkg::CFG_INNOV_MODE) begin
        innovation_mode <= cfg_data;
      end else if (cfg_index == sfi_pkg::CFG_POINTS) begin
        points_in_use <= cfg_data[4:0];
      end
    end
  end

  sfi_front u_front (
    .tdata           (s_tdata),
    .tuser           (s_tuser),
    .innovation_mode (innovation_mode),
    .item            (front_item)
  );

  sfi_queue #(
    .DEPTH (sfi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_tvalid),
    .wr_ready (s_tready),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  sfi_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .points_in_use (points_in_use),
    .item_valid    (q_valid),
    .item_ready    (q_ready),
    .item          (q_item),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .sigma         (m_tdata),
    .out_miss      (m_tuser)
  );

endmodule
`default_nettype wire

### test/sigma_from_innovation_interp_checker.sv
// ----------------------------------------------------------------------------
// sigma_from_innovation_interp_checker
// Watches the input, output and config channels of the sigma lookup block,
// predicts sigma for every compute beat from a private copy of the table
// and registers, and compares each output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sigma_from_innovation_interp_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [23:0]  m_tdata,
  input  logic         m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fails,
  output int           pending
);

  localparam int NPTS = 16;

  typedef struct packed {
    logic [23:0] sigma;
    logic        missing;
  } sigma_res_t;

  logic signed [31:0] mode_reg;
  logic [4:0]         points_reg;
  logic signed [31:0] grid_copy [NPTS];
  logic [31:0]        var_copy [NPTS];
  sigma_res_t         sigma_q [$];

  // variance interpolated at centered innovation r
  function automatic logic [31:0] variance_at_r(longint r);
    int          n;
    int          j;
    longint      x0, x1;
    logic [63:0] y0, y1, dx, dr, prod, q;
    n = (points_reg == 0) ? 1 : (points_reg > NPTS) ? NPTS : points_reg;
    if (n == 1) return var_copy[0];
    if (r <= longint'(grid_copy[0])) return var_copy[0];
    if (r >= longint'(grid_copy[n-1])) return var_copy[n-1];
    j = 1;
    while (j < n - 1 && longint'(grid_copy[j]) <= r) j++;
    x0 = grid_copy[j-1];
    x1 = grid_copy[j];
    y0 = {32'd0, var_copy[j-1]};
    y1 = {32'd0, var_copy[j]};
    dx = 64'(x1 - x0);
    dr = 64'(r - x0);
    if (y1 >= y0) begin
      prod = dr * (y1 - y0);
      q = prod / dx;
      return 32'(y0 + q);
    end
    prod = dr * (y0 - y1);
    q = prod / dx;
    if (q * dx != prod) q++;   // floor toward minus infinity
    return 32'(y0 - q);
  endfunction

  // floor square root of a Q16.16 variance, Q8.16 result
  function automatic logic [23:0] root_q16(logic [31:0] v);
    logic [63:0] x, res, trial;
    x = {16'd0, v, 16'd0};
    res = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= x) res = trial;
    end
    return res[23:0];
  endfunction

  assign pending = sigma_q.size();

  always @(posedge clk) begin
    sigma_res_t exp_res;
    longint     r;
    if (rst) begin
      mode_reg <= 0;
      points_reg <= 1;
      for (int i = 0; i < NPTS; i++) begin
        grid_copy[i] <= 0;
        var_copy[i] <= 0;
      end
      sigma_q.delete();
      fails <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sfi_pkg::CFG_INNOV_MODE) mode_reg <= cfg_data;
        else if (cfg_index == sfi_pkg::CFG_POINTS) points_reg <= cfg_data[4:0];
      end
      // input beat: load updates the table, compute queues a prediction
      if (s_tvalid && s_tready) begin
        if (s_tuser[0]) begin
          grid_copy[s_tdata[67:64]] <= s_tdata[99:68];
          var_copy[s_tdata[67:64]] <= s_tdata[131:100];
        end else if (s_tuser[1] || s_tuser[2]) begin
          exp_res.sigma = 0;
          exp_res.missing = 1'b1;
          sigma_q.push_back(exp_res);
        end else begin
          r = longint'($signed(s_tdata[31:0])) - longint'($signed(s_tdata[63:32]))
              - longint'(mode_reg);
          exp_res.sigma = root_q16(variance_at_r(r));
          exp_res.missing = 1'b0;
          sigma_q.push_back(exp_res);
        end
      end
      // output beat
      if (m_tvalid && m_tready) begin
        if (sigma_q.size() == 0) begin
          $error("unexpected output beat: sigma %0d missing %0d", m_tdata, m_tuser);
          fails <= fails + 1;
        end else begin
          exp_res = sigma_q.pop_front();
          if (m_tdata !== exp_res.sigma || m_tuser !== exp_res.missing) begin
            if (m_tdata !== exp_res.sigma)
              $error("sigma: expected %0d, got %0d", exp_res.sigma, m_tdata);
            if (m_tuser !== exp_res.missing)
              $error("sigma_missing: expected %0d, got %0d", exp_res.missing, m_tuser);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

### test/sigma_from_innovation_interp_tb.sv
// ----------------------------------------------------------------------------
// sigma_from_innovation_interp_tb
// Stimulus for the sigma lookup block: loads variance tables, sweeps the
// mode and point-count registers through their extremes, and streams
// observations aimed at grid points, segment interiors and beyond the ends,
// with random idle cycles on both streams. The checker does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sigma_from_innovation_interp_tb;

  localparam int          NPTS        = 16;
  localparam logic [7:0]  CFG_UNUSED  = 8'd2;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN       = 160;
  localparam longint      S32_MIN     = -64'sd2147483648;
  localparam longint      S32_MAX     = 64'sd2147483647;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [23:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fails;
  int           pending;
  int           cycles;
  bit           quiet;     // no idling while set

  // own view of the table and registers, for aiming observations
  longint       grid_tb [NPTS];
  logic [31:0]  var_tb [NPTS];
  longint       mode_tb;
  int           npts_tb;

  sigma_from_innovation_interp dut (.*);
  sigma_from_innovation_interp_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run-time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sink-side stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(99) >= 7);
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sfi_pkg::CFG_INNOV_MODE) mode_tb = longint'($signed(val));
    else if (idx == sfi_pkg::CFG_POINTS)
      npts_tb = (val[4:0] == 0) ? 1 : (val[4:0] > NPTS) ? NPTS : val[4:0];
  endtask

  task automatic send_beat(bit op, logic [31:0] obs, logic [31:0] model, bit om, bit mm,
                           logic [3:0] idx, logic [31:0] gp, logic [31:0] vv);
    while (!quiet && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, vv, gp, idx, model, obs};
    s_tuser <= {mm, om, op};
    do @(posedge clk); while (!s_tready);
    if (op) begin
      grid_tb[idx] = longint'($signed(gp));
      var_tb[idx] = vv;
    end
  endtask

  task automatic load_entry(int i, longint gp, logic [31:0] vv);
    send_beat(1'b1, $urandom, $urandom, $urandom, $urandom, 4'(i), 32'(gp), vv);
  endtask

  // compute beat whose centered innovation equals r
  task automatic observe_at(longint r, bit om = 0, bit mm = 0);
    longint t, lo, hi, obs;
    t = r + mode_tb;
    lo = (t - 64'sd2147483648 > S32_MIN) ? t - 64'sd2147483648 : S32_MIN;
    hi = (t + S32_MAX < S32_MAX) ? t + S32_MAX : S32_MAX;
    obs = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
    send_beat(1'b0, 32'(obs), 32'(obs - t), om, mm, $urandom, $urandom, $urandom);
  endtask

  // random increasing table
  task automatic load_table();
    longint step_max, g;
    logic [31:0] vv;
    case ($urandom_range(2))
      0: step_max = 4;
      1: step_max = 65536;
      default: step_max = 64'sd134217728;
    endcase
    g = S32_MIN + longint'({$urandom, $urandom} % 64'(64'sd4294967295 - 15 * step_max));
    for (int i = 0; i < NPTS; i++) begin
      case ($urandom_range(5))
        0: vv = 0;
        1: vv = 32'hFFFF_FFFF;
        2: vv = $urandom_range(1000);
        default: vv = $urandom;
      endcase
      load_entry(i, g, vv);
      g += longint'($urandom_range(32'(step_max - 1))) + 1;
    end
  endtask

  // let every result out, then give the back end time to settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_observation();
    int k;
    k = $urandom_range(npts_tb - 1);
    case ($urandom_range(9))
      0, 1: observe_at(grid_tb[k]);
      2, 3, 4: begin
        if (k + 1 < npts_tb)
          observe_at(grid_tb[k] + longint'({$urandom, $urandom} %
                     64'(grid_tb[k+1] - grid_tb[k])));
        else observe_at(grid_tb[k] + 1);
      end
      5: observe_at(grid_tb[0] - $urandom_range(1000));
      6: observe_at(grid_tb[npts_tb-1] + $urandom_range(1000));
      7: send_beat(1'b0, $urandom, $urandom, 1'b0, 1'b0, $urandom, $urandom, $urandom);
      8: observe_at(grid_tb[k], $urandom_range(1), $urandom_range(1));
      default: observe_at(grid_tb[k] + 1);
    endcase
  endtask

  initial begin
    logic [31:0] mode_pick;
    logic [31:0] pts_pick;
    cycles = 0;
    quiet = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mode_tb = 0;
    npts_tb = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: table spanning the whole signed range, both variance extremes
    for (int i = 0; i < NPTS; i++)
      load_entry(i, (i == NPTS - 1) ? S32_MAX : S32_MIN + i * 64'sd268435456,
                 (i % 3 == 0) ? 32'hFFFF_FFFF : (i % 3 == 1) ? 32'd0 : 32'h0001_0000);
    observe_at(grid_tb[0]);                     // single point in use
    drain();
    write_reg(sfi_pkg::CFG_POINTS, 16);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);       // no register there
    observe_at(S32_MIN);
    observe_at(S32_MAX);
    observe_at(grid_tb[1] - 1);                 // falling segment
    observe_at(grid_tb[2] + 12345);             // rising segment
    observe_at(grid_tb[7]);
    send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 0, 0);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 0, 0, 0);
    observe_at(0, 1'b1, 1'b0);
    observe_at(0, 1'b0, 1'b1);
    observe_at(0, 1'b1, 1'b1);
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin mode_pick = 32'h8000_0000; pts_pick = 0;  end
        1: begin mode_pick = 32'h7FFF_FFFF; pts_pick = 31; end
        2: begin mode_pick = 0;             pts_pick = 16; end
        3: begin mode_pick = $urandom;      pts_pick = 2;  end
        default: begin mode_pick = $urandom; pts_pick = $urandom_range(31); end
      endcase
      quiet = (ph == 2);
      write_reg(sfi_pkg::CFG_INNOV_MODE, mode_pick);
      write_reg(sfi_pkg::CFG_POINTS, pts_pick);
      if (ph != 0) load_table();
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(19) == 0) begin
          int k;
          k = $urandom_range(NPTS - 1);
          load_entry(k, grid_tb[k], $urandom);  // new variance, same grid
        end else random_observation();
      end
      drain();
    end

    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/sfi_pkg.sv
rtl/sfi_front.sv
rtl/sfi_queue.sv
rtl/sfi_back.sv
rtl/sigma_from_innovation_interp.sv
test/sigma_from_innovation_interp_checker.sv
test/sigma_from_innovation_interp_tb.sv
